// ===== hdl/tpw_pkg.sv =====
`timescale 1ns / 1ps
package tpw_pkg;

  // Stream payload widths, padded to whole bytes.
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 40;

  localparam int VA_W    = 32;
  localparam int LEN_W   = 3;
  localparam int FRAME_W = 20;
  localparam int OFF_W   = 12;
  localparam int IDX_W   = 10;
  localparam int KIND_W  = 2;
  localparam int CODE_W  = 2;
  localparam int PHASE_W = 2;

  // Input transaction commands.
  localparam logic CMD_ACCESS   = 1'b0;
  localparam logic CMD_RESPONSE = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_REQ   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_XLAT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FAULT = 2'd2;

  // Fault codes.
  localparam logic [CODE_W-1:0] FLT_NONE  = 2'd0;
  localparam logic [CODE_W-1:0] FLT_CROSS = 2'd1;
  localparam logic [CODE_W-1:0] FLT_DIR   = 2'd2;
  localparam logic [CODE_W-1:0] FLT_TAB   = 2'd3;

  // Walk phases.
  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DIR  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_TAB  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_PAGING_ENABLE = 1'b0;
  localparam logic CFG_DIR_FRAME     = 1'b1;

  localparam logic [OFF_W:0] PAGE_BYTES = 13'd4096;

  typedef struct packed {
    logic             command;
    logic [VA_W-1:0]  virt_addr;
    logic [LEN_W-1:0] access_len;
    logic             is_write;
    logic [VA_W-1:0]  mem_word;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VA_W-1:0]   phys_addr;
    logic [LEN_W-1:0]  out_len;
    logic              out_write;
    logic [CODE_W-1:0] fault_code;
  } rsp_t;

endpackage

// ===== hdl/tpw_in_reg.sv =====
`timescale 1ns / 1ps
module tpw_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tpw_pkg::req_t in_req,
  input  logic          advance,
  output logic          held_valid,
  output tpw_pkg::req_t held_req
);
  import tpw_pkg::*;

  logic load;

  // The stage frees itself in the same cycle that its item moves on.
  assign in_ready = !held_valid || advance;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_req <= in_req;
    end
  end

endmodule

// ===== hdl/tpw_walk.sv =====
`timescale 1ns / 1ps
module tpw_walk (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  tpw_pkg::req_t                req,
  input  logic                         paging_enable,
  input  logic [tpw_pkg::FRAME_W-1:0]  dir_frame,
  output logic                         rsp_valid,
  output tpw_pkg::rsp_t                rsp
);
  import tpw_pkg::*;

  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic [VA_W-1:0]    held_vaddr;
  logic [LEN_W-1:0]   held_len;
  logic               held_write;
  logic               capture;
  logic [OFF_W:0]     end_offset;
  logic               crosses;
  logic               present;

  assign end_offset = {1'b0, req.virt_addr[OFF_W-1:0]} + {{(OFF_W+1-LEN_W){1'b0}}, req.access_len};
  assign crosses    = end_offset > PAGE_BYTES;
  assign present    = req.mem_word[0];

  always_comb begin
    phase_next = phase;
    capture    = 1'b0;
    rsp_valid  = 1'b0;
    rsp        = '{kind: KIND_REQ, phys_addr: '0, out_len: '0, out_write: 1'b0,
                   fault_code: FLT_NONE};
    if (req.command == CMD_ACCESS) begin
      if (phase == PH_IDLE) begin
        rsp_valid = 1'b1;
        if (!paging_enable) begin
          rsp.kind      = KIND_XLAT;
          rsp.phys_addr = req.virt_addr;
          rsp.out_len   = req.access_len;
          rsp.out_write = req.is_write;
        end else if (crosses) begin
          rsp.kind       = KIND_FAULT;
          rsp.phys_addr  = req.virt_addr;
          rsp.fault_code = FLT_CROSS;
        end else begin
          capture       = 1'b1;
          phase_next    = PH_DIR;
          rsp.phys_addr = {dir_frame, req.virt_addr[VA_W-1 -: IDX_W], 2'b00};
        end
      end
    end else begin
      unique case (phase)
        PH_DIR: begin
          rsp_valid = 1'b1;
          if (!present) begin
            phase_next     = PH_IDLE;
            rsp.kind       = KIND_FAULT;
            rsp.phys_addr  = held_vaddr;
            rsp.fault_code = FLT_DIR;
          end else begin
            phase_next    = PH_TAB;
            rsp.phys_addr = {req.mem_word[VA_W-1:OFF_W], held_vaddr[OFF_W+IDX_W-1:OFF_W],
                             2'b00};
          end
        end
        PH_TAB: begin
          rsp_valid  = 1'b1;
          phase_next = PH_IDLE;
          if (!present) begin
            rsp.kind       = KIND_FAULT;
            rsp.phys_addr  = held_vaddr;
            rsp.fault_code = FLT_TAB;
          end else begin
            rsp.kind      = KIND_XLAT;
            rsp.phys_addr = {req.mem_word[VA_W-1:OFF_W], held_vaddr[OFF_W-1:0]};
            rsp.out_len   = held_len;
            rsp.out_write = held_write;
          end
        end
        default: begin
          // A response with no walk in progress is dropped.
          rsp_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && capture) begin
      held_vaddr <= req.virt_addr;
      held_len   <= req.access_len;
      held_write <= req.is_write;
    end
  end

`ifndef SYNTHESIS
  a_walk_starts: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_IDLE && rsp_valid && rsp.kind == KIND_REQ |=> phase == PH_DIR)
    else $error("walk did not enter directory phase");

  a_tab_ends: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_TAB && req.command == CMD_RESPONSE |=> phase == PH_IDLE)
    else $error("walk did not end after table entry");

  a_tab_fault_src: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.fault_code == FLT_TAB |-> phase == PH_TAB)
    else $error("table fault outside table phase");

  a_busy_drops_access: assert property (@(posedge clk) disable iff (rst)
    req.command == CMD_ACCESS && phase != PH_IDLE |-> !rsp_valid)
    else $error("access during a walk produced a result");
`endif

endmodule

// ===== hdl/tpw_out_reg.sv =====
`timescale 1ns / 1ps
module tpw_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  tpw_pkg::rsp_t load_rsp,
  output logic          can_accept,
  output logic          out_valid,
  input  logic          out_ready,
  output tpw_pkg::rsp_t out_rsp
);
  import tpw_pkg::*;

  assign can_accept = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rsp <= load_rsp;
    end
  end

endmodule

// ===== hdl/two_level_page_walker.sv =====
`timescale 1ns / 1ps
// Path: a transaction accepted into the input register passes the combinational
//   walk step into the result register, which drives the master side; a master-side stall holds it.
// Throughput: one transaction per cycle while the master side takes results.
// Reset (rst, synchronous, active high): paging off, directory frame zero,
//   walk idle, both pipeline registers empty.
module two_level_page_walker (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port.
  input  logic                             cfg_wen,
  input  logic                             cfg_index,
  input  logic [tpw_pkg::FRAME_W-1:0]      cfg_data,
  // Slave side: tdata = virt_addr[31:0], access_len[34:32], is_write[35],
  //   mem_word[67:36], zero pad[71:68]; tuser = command.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tpw_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  logic                             s_axis_tuser,
  // Master side: tdata = phys_addr[31:0], out_len[34:32], out_write[35],
  //   fault_code[37:36], zero pad[39:38]; tuser = kind.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tpw_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic [tpw_pkg::KIND_W-1:0]       m_axis_tuser
);
  import tpw_pkg::*;

  // Configuration registers. They must be written only while no transaction
  // is in the pipeline; the block itself does not enforce this. A walk that is
  // already running keeps the directory address it started with, so it completes as begun.
  logic               paging_enable;
  logic [FRAME_W-1:0] dir_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      paging_enable <= 1'b0;
      dir_frame     <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_PAGING_ENABLE: paging_enable <= cfg_data[0];
        CFG_DIR_FRAME:     dir_frame     <= cfg_data;
        default:           paging_enable <= paging_enable;
      endcase
    end
  end

  // Unpack the incoming transaction.
  req_t in_req;
  assign in_req = '{command:    s_axis_tuser,
                    virt_addr:  s_axis_tdata[31:0],
                    access_len: s_axis_tdata[34:32],
                    is_write:   s_axis_tdata[35],
                    mem_word:   s_axis_tdata[67:36]};

  logic advance;
  logic held_valid;
  req_t held_req;
  logic can_accept;
  logic rsp_valid;
  rsp_t rsp;
  rsp_t out_rsp;

  // The held transaction is processed whenever the result register can take
  // a result. A transaction that yields no result still moves on, so the
  // input side keeps flowing even when nothing is produced.
  assign advance = held_valid && can_accept;

  tpw_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_req     (in_req),
    .advance    (advance),
    .held_valid (held_valid),
    .held_req   (held_req)
  );

  // Walk state and the one-step translation logic. The walk phase advances
  // only when a transaction is processed, so results come out in order.
  tpw_walk u_walk (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .req           (held_req),
    .paging_enable (paging_enable),
    .dir_frame     (dir_frame),
    .rsp_valid     (rsp_valid),
    .rsp           (rsp)
  );

  // The result register decouples the master side; it accepts a new result
  // in the same cycle its current one is taken.
  tpw_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && rsp_valid),
    .load_rsp   (rsp),
    .can_accept (can_accept),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_rsp    (out_rsp)
  );

  assign m_axis_tdata = {2'b00, out_rsp.fault_code, out_rsp.out_write, out_rsp.out_len,
                         out_rsp.phys_addr};
  assign m_axis_tuser = out_rsp.kind;

endmodule
